>>> hw/rtl/assert_macros.svh
// Assertion helpers included by four_wheel_drive_mixer.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define FWDM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define FWDM_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> hw/rtl/fwdm_pkg.sv
package fwdm_pkg;

  localparam int MoveW   = 3;
  localparam int TrimW   = 8;
  localparam int CorrW   = 10;
  localparam int DutyW   = 8;
  localparam int ScaleW  = 16;
  localparam int SpeedW  = 16;
  localparam int RawW    = 12;
  localparam int SumW    = 10;
  localparam int ProdW   = SumW + ScaleW;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 16;
  localparam int Wheels  = 4;

  typedef logic [MoveW-1:0]       move_t;
  typedef logic [DutyW-1:0]       duty_t;
  typedef logic signed [RawW-1:0] raw_t;

  typedef enum logic [1:0] {
    DRV_STANDBY  = 2'd0,
    DRV_FORWARD  = 2'd1,
    DRV_BACKWARD = 2'd2,
    DRV_BRAKE    = 2'd3
  } drv_t;

  localparam move_t MV_BRAKE    = 3'd0;
  localparam move_t MV_FORWARD  = 3'd1;
  localparam move_t MV_BACKWARD = 3'd2;
  localparam move_t MV_LEFT     = 3'd3;
  localparam move_t MV_RIGHT    = 3'd4;
  localparam move_t MV_ROTATE   = 3'd5;
  localparam move_t MV_STANDBY  = 3'd6;

  localparam logic [CfgIdxW-1:0] REG_STRAIGHT_BASE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LATERAL_BASE  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ROTATE_DUTY   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_RIGHT_THR     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LEFT_THR      = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DUTY_CEILING  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_SPEED_SCALE   = 3'd6;

  localparam duty_t             RST_STRAIGHT_BASE = 8'd75;
  localparam duty_t             RST_LATERAL_BASE  = 8'd80;
  localparam duty_t             RST_ROTATE_DUTY   = 8'd80;
  localparam duty_t             RST_RIGHT_THR     = 8'd60;
  localparam duty_t             RST_LEFT_THR      = 8'd70;
  localparam duty_t             RST_DUTY_CEILING  = 8'd200;
  localparam logic [ScaleW-1:0] RST_SPEED_SCALE   = 16'd43647;

endpackage

>>> hw/rtl/fwdm_if.sv
interface fwdm_in_if import fwdm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  move_t                    move;
  logic signed [TrimW-1:0]  speed_trim;
  logic signed [CorrW-1:0]  steer_correction;

  modport source (output valid, move, speed_trim, steer_correction, input ready);
  modport sink (input valid, move, speed_trim, steer_correction, output ready);
endinterface

interface fwdm_out_if import fwdm_pkg::*; ();
  logic              valid;
  logic              ready;
  duty_t             duty_front_left;
  duty_t             duty_front_right;
  duty_t             duty_rear_left;
  duty_t             duty_rear_right;
  drv_t              drive_front_left;
  drv_t              drive_front_right;
  drv_t              drive_rear_left;
  drv_t              drive_rear_right;
  logic [SpeedW-1:0] speed_x;
  logic [SpeedW-1:0] speed_y;

  modport source (output valid, duty_front_left, duty_front_right, duty_rear_left,
                  duty_rear_right, drive_front_left, drive_front_right, drive_rear_left,
                  drive_rear_right, speed_x, speed_y, input ready);
  modport sink (input valid, duty_front_left, duty_front_right, duty_rear_left,
                duty_rear_right, drive_front_left, drive_front_right, drive_rear_left,
                drive_rear_right, speed_x, speed_y, output ready);
endinterface

interface fwdm_cfg_if import fwdm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/four_wheel_drive_mixer.sv
// Each accepted input word passes through every register stage below before its result word reaches the output.
// Throughput: one word per cycle; four register stages (raw duty, wheel clamp,
// duty sum, speed multiply) each take a new word whenever the next stage moves.
// Reset (rst_n low at a clock edge) empties the pipeline and returns every
// configuration register to its default. Configuration writes are taken every cycle.
module four_wheel_drive_mixer import fwdm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  fwdm_in_if.sink    in_bus,
  fwdm_out_if.source out_bus,
  fwdm_cfg_if.sink   cfg_bus
);

`include "assert_macros.svh"

  typedef struct packed {
    move_t mv;
    raw_t  bp;
    raw_t  bm;
    logic  rot_right;
  } s1_t;

  typedef struct packed {
    move_t                  mv;
    duty_t [Wheels-1:0]     duty;
    drv_t  [Wheels-1:0]     drv;
  } s2_t;

  typedef struct packed {
    move_t                  mv;
    duty_t [Wheels-1:0]     duty;
    drv_t  [Wheels-1:0]     drv;
    logic  [SumW-1:0]       sum;
  } s3_t;

  typedef struct packed {
    duty_t [Wheels-1:0]     duty;
    drv_t  [Wheels-1:0]     drv;
    logic  [SpeedW-1:0]     sx;
    logic  [SpeedW-1:0]     sy;
  } s4_t;

  duty_t             straight_base_r, lateral_base_r, rotate_duty_r;
  duty_t             right_thr_r, left_thr_r, ceiling_r;
  logic [ScaleW-1:0] scale_r;

  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;
  s4_t  s4_r, s4_nxt;
  logic rdy1, rdy2, rdy3, rdy4;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      straight_base_r <= RST_STRAIGHT_BASE;
      lateral_base_r  <= RST_LATERAL_BASE;
      rotate_duty_r   <= RST_ROTATE_DUTY;
      right_thr_r     <= RST_RIGHT_THR;
      left_thr_r      <= RST_LEFT_THR;
      ceiling_r       <= RST_DUTY_CEILING;
      scale_r         <= RST_SPEED_SCALE;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        REG_STRAIGHT_BASE: straight_base_r <= cfg_bus.data[DutyW-1:0];
        REG_LATERAL_BASE:  lateral_base_r  <= cfg_bus.data[DutyW-1:0];
        REG_ROTATE_DUTY:   rotate_duty_r   <= cfg_bus.data[DutyW-1:0];
        REG_RIGHT_THR:     right_thr_r     <= cfg_bus.data[DutyW-1:0];
        REG_LEFT_THR:      left_thr_r      <= cfg_bus.data[DutyW-1:0];
        REG_DUTY_CEILING:  ceiling_r       <= cfg_bus.data[DutyW-1:0];
        REG_SPEED_SCALE:   scale_r         <= cfg_bus.data[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  assign rdy4 = !s4_v_r || out_bus.ready;
  assign rdy3 = !s3_v_r || rdy4;
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;
  assign in_bus.ready = rdy1;

  always_comb begin
    duty_t base;
    raw_t  b;
    raw_t  corr;
    if (in_bus.move inside {MV_FORWARD, MV_BACKWARD}) begin
      base = straight_base_r;
    end else begin
      base = lateral_base_r;
    end
    corr = $signed({{(RawW-CorrW){in_bus.steer_correction[CorrW-1]}},
                    in_bus.steer_correction});
    b = $signed({{(RawW-DutyW){1'b0}}, base}) +
        $signed({{(RawW-TrimW){in_bus.speed_trim[TrimW-1]}}, in_bus.speed_trim});
    s1_nxt.mv        = in_bus.move;
    s1_nxt.bp        = b + corr;
    s1_nxt.bm        = b - corr;
    s1_nxt.rot_right = (in_bus.steer_correction > 0);
  end

  always_comb begin
    raw_t  raw  [Wheels];
    drv_t  nrm  [Wheels];
    duty_t thr;
    raw_t  ceil_ext;
    logic  straight, lateral;
    straight = 1'b0;
    lateral  = 1'b0;
    thr      = right_thr_r;
    ceil_ext = $signed({{(RawW-DutyW){1'b0}}, ceiling_r});
    for (int i = 0; i < Wheels; i++) begin
      raw[i] = s1_r.bp;
      nrm[i] = DRV_STANDBY;
    end
    s2_nxt.mv = s1_r.mv;
    for (int i = 0; i < Wheels; i++) begin
      s2_nxt.duty[i] = '0;
      s2_nxt.drv[i]  = DRV_STANDBY;
    end
    case (s1_r.mv)
      MV_FORWARD: begin
        straight = 1'b1;
        raw[0] = s1_r.bp; raw[1] = s1_r.bm; raw[2] = s1_r.bm; raw[3] = s1_r.bp;
        for (int i = 0; i < Wheels; i++) nrm[i] = DRV_FORWARD;
      end
      MV_BACKWARD: begin
        straight = 1'b1;
        raw[0] = s1_r.bm; raw[1] = s1_r.bp; raw[2] = s1_r.bp; raw[3] = s1_r.bm;
        for (int i = 0; i < Wheels; i++) nrm[i] = DRV_BACKWARD;
      end
      MV_RIGHT: begin
        lateral = 1'b1;
        thr = right_thr_r;
        raw[0] = s1_r.bp; raw[1] = s1_r.bp; raw[2] = s1_r.bm; raw[3] = s1_r.bm;
        nrm[0] = DRV_BACKWARD; nrm[1] = DRV_FORWARD;
        nrm[2] = DRV_BACKWARD; nrm[3] = DRV_FORWARD;
      end
      MV_LEFT: begin
        lateral = 1'b1;
        thr = left_thr_r;
        raw[0] = s1_r.bm; raw[1] = s1_r.bm; raw[2] = s1_r.bp; raw[3] = s1_r.bp;
        nrm[0] = DRV_FORWARD; nrm[1] = DRV_BACKWARD;
        nrm[2] = DRV_FORWARD; nrm[3] = DRV_BACKWARD;
      end
      MV_ROTATE: begin
        for (int i = 0; i < Wheels; i++) s2_nxt.duty[i] = rotate_duty_r;
        s2_nxt.drv[0] = s1_r.rot_right ? DRV_FORWARD : DRV_BACKWARD;
        s2_nxt.drv[3] = s1_r.rot_right ? DRV_FORWARD : DRV_BACKWARD;
        s2_nxt.drv[1] = s1_r.rot_right ? DRV_BACKWARD : DRV_FORWARD;
        s2_nxt.drv[2] = s1_r.rot_right ? DRV_BACKWARD : DRV_FORWARD;
      end
      MV_BRAKE: begin
        for (int i = 0; i < Wheels; i++) s2_nxt.drv[i] = DRV_BRAKE;
      end
      default: ;
    endcase
    for (int i = 0; i < Wheels; i++) begin
      if (straight) begin
        s2_nxt.drv[i] = nrm[i];
        if (raw[i] < $signed({{(RawW-1){1'b0}}, 1'b1})) begin
          s2_nxt.duty[i] = (ceiling_r == '0) ? '0 : duty_t'(1);
        end else if (raw[i] > ceil_ext) begin
          s2_nxt.duty[i] = ceiling_r;
        end else begin
          s2_nxt.duty[i] = raw[i][DutyW-1:0];
        end
      end else if (lateral) begin
        if (raw[i] < $signed({{(RawW-DutyW){1'b0}}, thr})) begin
          s2_nxt.duty[i] = lateral_base_r;
          s2_nxt.drv[i]  = (nrm[i] == DRV_FORWARD) ? DRV_BACKWARD : DRV_FORWARD;
        end else begin
          s2_nxt.drv[i]  = nrm[i];
          s2_nxt.duty[i] = (raw[i] > ceil_ext) ? ceiling_r : raw[i][DutyW-1:0];
        end
      end
    end
  end

  always_comb begin
    s3_nxt.mv   = s2_r.mv;
    s3_nxt.duty = s2_r.duty;
    s3_nxt.drv  = s2_r.drv;
    s3_nxt.sum  = SumW'({2'b00, s2_r.duty[0]}) + SumW'({2'b00, s2_r.duty[1]}) +
                  SumW'({2'b00, s2_r.duty[2]}) + SumW'({2'b00, s2_r.duty[3]});
  end

  always_comb begin
    logic [ProdW-1:0]  prod;
    logic [SpeedW-1:0] sp;
    prod = {{ScaleW{1'b0}}, s3_r.sum} * {{SumW{1'b0}}, scale_r};
    sp   = prod[ProdW-1:SumW];
    s4_nxt.duty = s3_r.duty;
    s4_nxt.drv  = s3_r.drv;
    s4_nxt.sx   = (s3_r.mv inside {MV_FORWARD, MV_BACKWARD}) ? sp : '0;
    s4_nxt.sy   = (s3_r.mv inside {MV_LEFT, MV_RIGHT}) ? sp : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r <= in_bus.valid;
      if (rdy2) s2_v_r <= s1_v_r;
      if (rdy3) s3_v_r <= s2_v_r;
      if (rdy4) s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_bus.valid) s1_r <= s1_nxt;
    if (rdy2 && s1_v_r) s2_r <= s2_nxt;
    if (rdy3 && s2_v_r) s3_r <= s3_nxt;
    if (rdy4 && s3_v_r) s4_r <= s4_nxt;
  end

  assign out_bus.valid             = s4_v_r;
  assign out_bus.duty_front_left   = s4_r.duty[0];
  assign out_bus.duty_front_right  = s4_r.duty[1];
  assign out_bus.duty_rear_left    = s4_r.duty[2];
  assign out_bus.duty_rear_right   = s4_r.duty[3];
  assign out_bus.drive_front_left  = s4_r.drv[0];
  assign out_bus.drive_front_right = s4_r.drv[1];
  assign out_bus.drive_rear_left   = s4_r.drv[2];
  assign out_bus.drive_rear_right  = s4_r.drv[3];
  assign out_bus.speed_x           = s4_r.sx;
  assign out_bus.speed_y           = s4_r.sy;

  `FWDM_ASSERT(a_s1_holds, s1_v_r && !rdy2 |=> s1_v_r, "stage one word dropped on stall")
  `FWDM_NEVER(a_one_speed, s4_v_r && s4_r.sx != '0 && s4_r.sy != '0, "both speeds set")
  `FWDM_ASSERT(a_brake_zero,
    s2_v_r && s2_r.drv[0] == DRV_BRAKE |-> s2_r.duty[0] == '0 && s2_r.duty[3] == '0,
    "braking wheel has a duty")
  `FWDM_ASSERT(a_sx_class,
    s3_v_r && rdy4 && !(s3_r.mv == MV_FORWARD || s3_r.mv == MV_BACKWARD) |=> s4_r.sx == '0,
    "speed_x set outside a straight move")

endmodule
